@@ rtl/core/srsm_pkg.sv @@
package srsm_pkg;

  // Field widths of one command beat and one result beat
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned SIZE_W  = 30;
  localparam int unsigned CRC_W   = 64;
  localparam int unsigned TYPE_W  = 32;
  localparam int unsigned CHAN_W  = 32;
  localparam int unsigned OFFS_W  = 32;
  localparam int unsigned OVF_W   = 32;
  localparam int unsigned BYTES_W = 64;

  localparam int unsigned IN_DATA_W  = 232;
  localparam int unsigned OUT_DATA_W = 424;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQ_WR   = 3'd0,
    CMD_SET_META = 3'd1,
    CMD_COMMIT   = 3'd2,
    CMD_ACQ_RD   = 3'd3,
    CMD_RELEASE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PH_FREE    = 2'd0,
    PH_WRITING = 2'd1,
    PH_READY   = 2'd2,
    PH_READING = 2'd3
  } phase_e;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [TYPE_W-1:0] ptype;
    logic [CRC_W-1:0]  crc;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } meta_t;

  // Decoded outcome of one command, handed from the control unit to the datapath
  typedef struct packed {
    logic granted;
    logic rs_ok;
    logic meta_we;
    logic add_wr;
    logic add_rd;
  } ctrl_t;

endpackage

@@ rtl/core/srsm_meta_mem.sv @@
module srsm_meta_mem #(
  parameter int unsigned SLOT_COUNT = 8,
  localparam int unsigned PtrW = $clog2(SLOT_COUNT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [PtrW-1:0]    waddr_i,
  input  srsm_pkg::meta_t    wdata_i,
  input  logic               re_i,
  input  logic [PtrW-1:0]    raddr_a_i,
  input  logic [PtrW-1:0]    raddr_b_i,
  output srsm_pkg::meta_t    rdata_a_o,
  output logic [srsm_pkg::SIZE_W-1:0] rsize_b_o
);

  srsm_pkg::meta_t mem_q [SLOT_COUNT];
  logic            vld_q [SLOT_COUNT];

  srsm_pkg::meta_t             rd_a_q;
  logic                        rd_a_vld_q;
  logic [srsm_pkg::SIZE_W-1:0] rd_b_q;
  logic                        rd_b_vld_q;

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Port A passes this beat's own write through
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_a_i)) begin
        rd_a_q     <= wdata_i;
        rd_a_vld_q <= 1'b1;
      end else begin
        rd_a_q     <= mem_q[raddr_a_i];
        rd_a_vld_q <= vld_q[raddr_a_i];
      end
      rd_b_q     <= mem_q[raddr_b_i].size;
      rd_b_vld_q <= vld_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_vld_q ? rd_a_q : '0;
  assign rsize_b_o = rd_b_vld_q ? rd_b_q : '0;

endmodule

@@ rtl/core/srsm_ctrl.sv @@
module srsm_ctrl #(
  parameter int unsigned SLOT_COUNT = 8,
  localparam int unsigned PtrW = $clog2(SLOT_COUNT),
  localparam int unsigned IdxW = (PtrW > srsm_pkg::SLOT_W) ? PtrW : srsm_pkg::SLOT_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [srsm_pkg::CMD_W-1:0]   cmd_i,
  input  logic [srsm_pkg::SLOT_W-1:0]  slot_i,
  input  logic                         enable_i,
  output srsm_pkg::ctrl_t              ctrl_o,
  output logic [IdxW-1:0]              rs_o,
  output logic [PtrW-1:0]              tgt_o,
  output logic [srsm_pkg::OVF_W-1:0]   ovf_o
);

  logic [PtrW-1:0]            wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [srsm_pkg::OVF_W-1:0] ovf_q;
  srsm_pkg::phase_e           phase_q [SLOT_COUNT];

  logic                       tgt_ok;
  logic [IdxW-1:0]            slot_ext;
  logic                       ph_we;
  logic [PtrW-1:0]            ph_addr;
  srsm_pkg::phase_e           ph_val;
  logic                       ovf_inc;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == PtrW'(SLOT_COUNT - 1)) ? '0 : p + PtrW'(1);
    return n;
  endfunction

  assign slot_ext = IdxW'(slot_i);
  assign tgt_ok   = (32'(slot_i) < 32'(SLOT_COUNT));
  assign tgt_o    = slot_ext[PtrW-1:0];

  always_comb begin
    ctrl_o   = '0;
    ctrl_o.rs_ok = tgt_ok;
    rs_o     = slot_ext;
    ph_we    = 1'b0;
    ph_addr  = tgt_o;
    ph_val   = srsm_pkg::PH_FREE;
    ovf_inc  = 1'b0;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    case (srsm_pkg::cmd_e'(cmd_i))
      srsm_pkg::CMD_ACQ_WR: begin
        rs_o         = IdxW'(wr_ptr_q);
        ctrl_o.rs_ok = 1'b1;
        if (enable_i) begin
          if (phase_q[wr_ptr_q] != srsm_pkg::PH_FREE) begin
            ovf_inc = 1'b1;
          end else begin
            ph_we          = 1'b1;
            ph_addr        = wr_ptr_q;
            ph_val         = srsm_pkg::PH_WRITING;
            ctrl_o.granted = 1'b1;
          end
        end
      end
      srsm_pkg::CMD_SET_META: begin
        if (tgt_ok) begin
          ctrl_o.meta_we = 1'b1;
          ctrl_o.granted = 1'b1;
        end
      end
      srsm_pkg::CMD_COMMIT: begin
        if (tgt_ok) begin
          ph_we          = 1'b1;
          ph_val         = srsm_pkg::PH_READY;
          wr_ptr_d       = ptr_next(wr_ptr_q);
          ctrl_o.add_wr  = 1'b1;
          ctrl_o.granted = 1'b1;
        end
      end
      srsm_pkg::CMD_ACQ_RD: begin
        rs_o         = IdxW'(rd_ptr_q);
        ctrl_o.rs_ok = 1'b1;
        if (enable_i && (phase_q[rd_ptr_q] == srsm_pkg::PH_READY)) begin
          ph_we          = 1'b1;
          ph_addr        = rd_ptr_q;
          ph_val         = srsm_pkg::PH_READING;
          ctrl_o.granted = 1'b1;
        end
      end
      srsm_pkg::CMD_RELEASE: begin
        if (tgt_ok) begin
          ph_we          = 1'b1;
          ph_val         = srsm_pkg::PH_FREE;
          rd_ptr_d       = ptr_next(rd_ptr_q);
          ctrl_o.add_rd  = 1'b1;
          ctrl_o.granted = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ovf_o = ovf_q + srsm_pkg::OVF_W'(ovf_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      ovf_q    <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        phase_q[i] <= srsm_pkg::PH_FREE;
      end
    end else if (accept_i) begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      ovf_q    <= ovf_o;
      if (ph_we) begin
        phase_q[ph_addr] <= ph_val;
      end
    end
  end

endmodule

@@ rtl/core/slot_ring_state_manager.sv @@
// Channel   Dir  tdata fields (low bit first)                         tuser
// s_axis    in   slot, payload_id, payload_size, payload_crc,         cmd
//                payload_kind, source_channel
// m_axis    out  result_slot, data_offset, meta_id, meta_size,        granted
//                meta_crc, meta_type, meta_channel, overflow_total,
//                bytes_written_total, bytes_read_total
// cfg       in   cfg_wdata = ring_enabled, written when cfg_we is high
//
// One command is taken every cycle while m_axis does not stall. The decode stage
// decodes the command, updates slot phases, pointers and the overflow count and
// reads the metadata memory; the output stage adds the byte totals and fills the
// output register.
// Reset clears phases to free, pointers, counters and metadata valid bits, and
// sets ring_enabled. A stalled m_axis holds the pipe and drops s_axis_tready once stage one is full.
module slot_ring_state_manager #(
  parameter int unsigned SLOT_COUNT   = 8,
  parameter int unsigned SLOT_BYTES   = 536870912,
  parameter int unsigned HEADER_BYTES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slot, payload_id, payload_size, payload_crc, payload_kind, source_channel
  input  logic [srsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd
  input  logic [srsm_pkg::CMD_W-1:0]          s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // result_slot, data_offset, meta_id, meta_size, meta_crc, meta_type,
  // meta_channel, overflow_total, bytes_written_total, bytes_read_total
  output logic [srsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // granted
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i
);

  localparam int unsigned PtrW = $clog2(SLOT_COUNT);
  localparam int unsigned IdxW = (PtrW > srsm_pkg::SLOT_W) ? PtrW : srsm_pkg::SLOT_W;

  // Unpack the command beat
  logic [srsm_pkg::SLOT_W-1:0] in_slot;
  srsm_pkg::meta_t             in_meta;
  logic [srsm_pkg::SIZE_W-1:0] in_size;

  assign in_slot         = s_axis_tdata[2:0];
  assign in_meta.id      = s_axis_tdata[66:3];
  assign in_size         = s_axis_tdata[96:67];
  assign in_meta.crc     = s_axis_tdata[160:97];
  assign in_meta.ptype   = s_axis_tdata[192:161];
  assign in_meta.channel = s_axis_tdata[224:193];

  // Clamp the stored size to one slot
  assign in_meta.size = (32'(in_size) > SLOT_BYTES) ? srsm_pkg::SIZE_W'(SLOT_BYTES) : in_size;

  logic enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Pipe handshake
  logic s1_valid_q, m_valid_q;
  logic out_free, s1_adv, accept;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode stage
  srsm_pkg::ctrl_t            ctrl;
  logic [IdxW-1:0]            rs;
  logic [PtrW-1:0]            tgt;
  logic [srsm_pkg::OVF_W-1:0] ovf;

  srsm_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (s_axis_tuser),
    .slot_i   (in_slot),
    .enable_i (enable_q),
    .ctrl_o   (ctrl),
    .rs_o     (rs),
    .tgt_o    (tgt),
    .ovf_o    (ovf)
  );

  srsm_pkg::meta_t             rd_meta;
  logic [srsm_pkg::SIZE_W-1:0] rd_size;

  srsm_meta_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_meta_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (accept && ctrl.meta_we),
    .waddr_i   (tgt),
    .wdata_i   (in_meta),
    .re_i      (accept),
    .raddr_a_i (rs[PtrW-1:0]),
    .raddr_b_i (tgt),
    .rdata_a_o (rd_meta),
    .rsize_b_o (rd_size)
  );

  // Stage one register: decode outcome, waiting for the memory read
  srsm_pkg::ctrl_t            s1_ctrl_q;
  logic [IdxW-1:0]            s1_rs_q;
  logic [srsm_pkg::OVF_W-1:0] s1_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q <= ctrl;
      s1_rs_q   <= rs;
      s1_ovf_q  <= ovf;
    end
  end

  // Output stage: byte totals advance as each result leaves stage one
  logic [srsm_pkg::BYTES_W-1:0] wr_bytes_q, wr_bytes_d;
  logic [srsm_pkg::BYTES_W-1:0] rd_bytes_q, rd_bytes_d;
  logic                         granted_q;
  logic [srsm_pkg::SLOT_W-1:0]  slot_q;
  logic [srsm_pkg::OFFS_W-1:0]  offs_q, offs_d;
  srsm_pkg::meta_t              meta_q;
  logic [srsm_pkg::OVF_W-1:0]   ovf_q;

  assign wr_bytes_d = wr_bytes_q +
                      (s1_ctrl_q.add_wr ? srsm_pkg::BYTES_W'(rd_size) : '0);
  assign rd_bytes_d = rd_bytes_q +
                      (s1_ctrl_q.add_rd ? srsm_pkg::BYTES_W'(rd_size) : '0);
  assign offs_d     = srsm_pkg::OFFS_W'(HEADER_BYTES) +
                      srsm_pkg::OFFS_W'(64'(s1_rs_q) * 64'(SLOT_BYTES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      wr_bytes_q <= '0;
      rd_bytes_q <= '0;
    end else begin
      if (s1_adv) begin
        m_valid_q  <= 1'b1;
        wr_bytes_q <= wr_bytes_d;
        rd_bytes_q <= rd_bytes_d;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      granted_q <= s1_ctrl_q.granted;
      slot_q    <= s1_rs_q[srsm_pkg::SLOT_W-1:0];
      offs_q    <= offs_d;
      // Out-of-range target reports zero metadata
      meta_q    <= s1_ctrl_q.rs_ok ? rd_meta : '0;
      ovf_q     <= s1_ovf_q;
    end
  end

  // Pack the result beat
  assign m_axis_tvalid        = m_valid_q;
  assign m_axis_tuser         = granted_q;
  assign m_axis_tdata[2:0]    = slot_q;
  assign m_axis_tdata[34:3]   = offs_q;
  assign m_axis_tdata[98:35]  = meta_q.id;
  assign m_axis_tdata[128:99] = meta_q.size;
  assign m_axis_tdata[192:129] = meta_q.crc;
  assign m_axis_tdata[224:193] = meta_q.ptype;
  assign m_axis_tdata[256:225] = meta_q.channel;
  assign m_axis_tdata[288:257] = ovf_q;
  assign m_axis_tdata[352:289] = wr_bytes_q;
  assign m_axis_tdata[416:353] = rd_bytes_q;
  assign m_axis_tdata[423:417] = '0;

endmodule
